@@ sv/morse_unit_encoder_defines.svh @@
// Assertion macros shared by the Morse unit encoder checkers
`ifndef MORSE_UNIT_ENCODER_DEFINES_SVH
`define MORSE_UNIT_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define MUE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MUE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/mue_pkg.sv @@
// Package: types, constants and code table for the Morse unit encoder
package mue_pkg;

   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [1:0] DOT_UNITS   = 2'd1;
   localparam logic [1:0] DASH_UNITS  = 2'd3;
   localparam logic [2:0] LETTER_TAIL = 3'd2;
   localparam logic [2:0] SPACE_TAIL  = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TONE,
      ST_GAP,
      ST_TAIL
   } state_type;

   // One table entry: symbol count, dash flags (bit 0 = first symbol), closing silence
   typedef struct packed {
      logic       known;
      logic [2:0] len;
      logic [5:0] dashes;
      logic [2:0] tail;
   } code_type;

   typedef struct packed {
      logic load;
      logic tone_step;
      logic sym_step;
      logic tail_step;
   } cmd_type;

   typedef struct packed {
      logic known;
      logic empty;
      logic tone_last;
      logic sym_last;
      logic tail_last;
   } status_type;

   // Build an entry from a pattern written in sending order, first symbol most significant
   function automatic code_type mk(input logic [2:0] len, input logic [5:0] pat);
      code_type c;
      c        = '0;
      c.known  = 1'b1;
      c.len    = len;
      c.tail   = LETTER_TAIL;
      for (int i = 0; i < 6; i++) begin
         if (i < int'(len)) begin
            c.dashes[i] = pat[3'(int'(len) - 1 - i)];
         end
      end
      return c;
   endfunction

   // Map a character byte to its Morse entry
   function automatic code_type lookup(input logic [7:0] ch);
      code_type c;
      c = '0;
      case (ch)
         SPACE_CHAR: begin
            c.known = 1'b1;
            c.tail  = SPACE_TAIL;
         end
         8'h61: c = mk(3'd2, 6'b000001);  // a
         8'h62: c = mk(3'd4, 6'b001000);  // b
         8'h63: c = mk(3'd4, 6'b001010);  // c
         8'h64: c = mk(3'd3, 6'b000100);  // d
         8'h65: c = mk(3'd1, 6'b000000);  // e
         8'h66: c = mk(3'd4, 6'b000010);  // f
         8'h67: c = mk(3'd3, 6'b000110);  // g
         8'h68: c = mk(3'd4, 6'b000000);  // h
         8'h69: c = mk(3'd2, 6'b000000);  // i
         8'h6a: c = mk(3'd4, 6'b000111);  // j
         8'h6b: c = mk(3'd3, 6'b000101);  // k
         8'h6c: c = mk(3'd4, 6'b000100);  // l
         8'h6d: c = mk(3'd2, 6'b000011);  // m
         8'h6e: c = mk(3'd2, 6'b000010);  // n
         8'h6f: c = mk(3'd3, 6'b000111);  // o
         8'h70: c = mk(3'd4, 6'b000110);  // p
         8'h71: c = mk(3'd4, 6'b001101);  // q
         8'h72: c = mk(3'd3, 6'b000010);  // r
         8'h73: c = mk(3'd3, 6'b000000);  // s
         8'h74: c = mk(3'd1, 6'b000001);  // t
         8'h75: c = mk(3'd3, 6'b000001);  // u
         8'h76: c = mk(3'd4, 6'b000001);  // v
         8'h77: c = mk(3'd3, 6'b000011);  // w
         8'h78: c = mk(3'd4, 6'b001001);  // x
         8'h79: c = mk(3'd4, 6'b001011);  // y
         8'h7a: c = mk(3'd4, 6'b001100);  // z
         8'h31: c = mk(3'd5, 6'b001111);  // 1
         8'h32: c = mk(3'd5, 6'b000111);  // 2
         8'h33: c = mk(3'd5, 6'b000011);  // 3
         8'h34: c = mk(3'd5, 6'b000001);  // 4
         8'h35: c = mk(3'd5, 6'b000000);  // 5
         8'h36: c = mk(3'd5, 6'b010000);  // 6
         8'h37: c = mk(3'd5, 6'b011000);  // 7
         8'h38: c = mk(3'd5, 6'b011100);  // 8
         8'h39: c = mk(3'd5, 6'b011110);  // 9
         8'h30: c = mk(3'd5, 6'b011111);  // 0
         8'h26: c = mk(3'd5, 6'b001000);  // ampersand
         8'h27: c = mk(3'd6, 6'b011110);  // apostrophe
         8'h40: c = mk(3'd6, 6'b011010);  // at sign
         8'h29, 8'h7d: c = mk(3'd6, 6'b101101);  // closing bracket and brace
         8'h28, 8'h7b: c = mk(3'd5, 6'b010110);  // opening bracket and brace
         8'h3a: c = mk(3'd6, 6'b111000);  // colon
         8'h2c: c = mk(3'd6, 6'b110011);  // comma
         8'h3d: c = mk(3'd5, 6'b010001);  // equals
         8'h21: c = mk(3'd6, 6'b101011);  // exclamation mark
         8'h2e: c = mk(3'd6, 6'b010101);  // full stop
         8'h2d: c = mk(3'd6, 6'b100001);  // hyphen
         8'h2b: c = mk(3'd5, 6'b001010);  // plus
         8'h22: c = mk(3'd6, 6'b010010);  // quotation mark
         8'h3f: c = mk(3'd6, 6'b001100);  // question mark
         8'h2f: c = mk(3'd5, 6'b010010);  // slash
         default: c.known = 1'b0;
      endcase
      return c;
   endfunction

endpackage

@@ sv/mue_datapath.sv @@
// Datapath: table lookup and the symbol, unit and silence counters
module mue_datapath (
   input  logic                 clock,
   input  logic [7:0]           req_character,
   input  mue_pkg::cmd_type     cmd,
   output mue_pkg::status_type  status
);

   mue_pkg::code_type code;

   logic [5:0] dash_ff,      dash_in;
   logic [2:0] sym_left_ff,  sym_left_in;
   logic [1:0] tone_left_ff, tone_left_in;
   logic [2:0] tail_left_ff, tail_left_in;

   // Look up the incoming word
   assign code = mue_pkg::lookup(req_character);

   // Load on accept, then count down units, symbols and closing silence
   always_comb begin
      dash_in      = dash_ff;
      sym_left_in  = sym_left_ff;
      tone_left_in = tone_left_ff;
      tail_left_in = tail_left_ff;
      if (cmd.load) begin
         dash_in      = code.dashes;
         sym_left_in  = code.len;
         tone_left_in = code.dashes[0] ? mue_pkg::DASH_UNITS : mue_pkg::DOT_UNITS;
         tail_left_in = code.tail;
      end else begin
         if (cmd.tone_step) begin
            tone_left_in = tone_left_ff - 2'd1;
         end
         if (cmd.sym_step) begin
            dash_in      = {1'b0, dash_ff[5:1]};
            sym_left_in  = sym_left_ff - 3'd1;
            tone_left_in = dash_ff[1] ? mue_pkg::DASH_UNITS : mue_pkg::DOT_UNITS;
         end
         if (cmd.tail_step) begin
            tail_left_in = tail_left_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dash_ff      <= dash_in;
      sym_left_ff  <= sym_left_in;
      tone_left_ff <= tone_left_in;
      tail_left_ff <= tail_left_in;
   end

   // Report to the controller
   always_comb begin
      status.known     = code.known;
      status.empty     = (code.len == 3'd0);
      status.tone_last = (tone_left_ff == 2'd1);
      status.sym_last  = (sym_left_ff == 3'd1);
      status.tail_last = (tail_left_ff == 3'd1);
   end

endmodule

@@ sv/mue_controller.sv @@
// Controller: state machine that sequences tone, gap and closing silence units
module mue_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_tone,
   output logic                 rsp_last_unit,
   input  mue_pkg::status_type  status,
   output mue_pkg::cmd_type     cmd
);

   mue_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mue_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, commands and the unit on offer
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      rsp_tone      = 1'b0;
      rsp_last_unit = 1'b0;
      case (state_ff)
         mue_pkg::ST_IDLE: begin
            // take a word; drop it if it has no code
            req_stall = 1'b0;
            if (req_valid && status.known) begin
               cmd.load = 1'b1;
               state_in = status.empty ? mue_pkg::ST_TAIL : mue_pkg::ST_TONE;
            end
         end
         mue_pkg::ST_TONE: begin
            rsp_valid = 1'b1;
            rsp_tone  = 1'b1;
            if (!rsp_stall) begin
               if (status.tone_last) begin
                  state_in = mue_pkg::ST_GAP;
               end else begin
                  cmd.tone_step = 1'b1;
               end
            end
         end
         mue_pkg::ST_GAP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.sym_last) begin
                  state_in = mue_pkg::ST_TAIL;
               end else begin
                  cmd.sym_step = 1'b1;
                  state_in     = mue_pkg::ST_TONE;
               end
            end
         end
         mue_pkg::ST_TAIL: begin
            rsp_valid     = 1'b1;
            rsp_last_unit = status.tail_last;
            if (!rsp_stall) begin
               if (status.tail_last) begin
                  state_in = mue_pkg::ST_IDLE;
               end else begin
                  cmd.tail_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = mue_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/morse_unit_encoder.sv @@
// Morse unit encoder: top level joining controller and datapath
// Takes one character word and sends its International Morse keying units, one
// per cycle while rsp_stall is low, each tone or silence, with last_unit set on
// the final one. A dot is one tone unit, a dash three, each symbol is followed
// by one silent unit and two more silent units close the letter; a space gives
// four silent units and any byte without a code is taken and gives nothing. The
// single unit sequencer sends one unit per cycle unless rsp_stall holds it, and
// the next word is taken only after the last unit of the current one has gone.
module morse_unit_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tone,
   output logic       rsp_last_unit
);

   mue_pkg::cmd_type    cmd;
   mue_pkg::status_type status;

   mue_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tone      (rsp_tone),
      .rsp_last_unit (rsp_last_unit),
      .status        (status),
      .cmd           (cmd)
   );

   mue_datapath u_dp (
      .clock         (clock),
      .req_character (req_character),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

@@ sv/mue_checker.sv @@
// Checker on the encoder ports, bound to the top level
`include "morse_unit_encoder_defines.svh"

module mue_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_character,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_tone,
   input logic       rsp_last_unit
);

   // a stalled unit holds
   `MUE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tone) && $stable(rsp_last_unit), "stalled unit changed")
   // no new word while units are on offer
   `MUE_ASSERT_NOW(a_busy_stall, clock, reset, rsp_valid, req_stall, "input open while sending")
   // the final unit frees the input
   `MUE_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && !rsp_stall && rsp_last_unit, !req_stall && !rsp_valid, "input not freed after final unit")
   // a space opens with silence
   `MUE_ASSERT_NEXT(a_space_silent, clock, reset, req_valid && !req_stall && (req_character == mue_pkg::SPACE_CHAR), rsp_valid && !rsp_tone && !rsp_last_unit, "space did not start silent")
   // a run always ends on silence
   `MUE_ASSERT_NOW(a_last_silent, clock, reset, rsp_valid && rsp_tone, !rsp_last_unit, "tone unit flagged last")

endmodule

bind morse_unit_encoder mue_checker u_mue_checker (.*);
